// File: rtl/core/ncm_pkg.sv
// Package for the node color mapper: modes, register map, fixed-point constants.
// No dependencies; imported by every module of the block.
`default_nettype none

package ncm_pkg;

  // Color hint field width and default number of hint bits used
  localparam int HintWidth       = 16;
  localparam int HintBitsDefault = 16;

  // Hue in 1/128 degree units: golden angle and one 60 degree sector
  localparam int Golden     = 17601;
  localparam int Sector     = 7680;

  // Full turn 46080 = 1024 * 45; high part reduced mod 45 by reciprocal
  localparam int Mod45      = 45;
  localparam int Recip45    = 2982617;  // ceil(2^27 / 45)
  localparam int RecipShift = 27;

  // mid = floor((MidBase + MidSlope * t) / 307200), t = 0..Sector
  localparam int MidBase    = 17625600;
  localparam int MidSlope   = 6885;
  localparam int MidRecip   = 55925;    // ceil(2^22 / 75)
  localparam int MidShift   = 22;

  localparam logic [7:0] LevelLow  = 8'd57;
  localparam logic [7:0] LevelHigh = 8'd229;

  // Register byte addresses
  localparam logic [2:0] AddrColorMode  = 3'd0;
  localparam logic [2:0] AddrFixedColor = 3'd4;

  typedef enum logic [1:0] {
    MODE_FIXED  = 2'd0,
    MODE_PARITY = 2'd1,
    MODE_HUE    = 2'd2,
    MODE_WHITE  = 2'd3
  } color_mode_t;

  typedef struct packed {
    color_mode_t color_mode;
    logic [31:0] fixed_color;
  } ncm_cfg_t;

  typedef logic [2:0] sector_t;

endpackage

`default_nettype wire

// File: rtl/core/node_color_mapper_core.sv
// Top level of the node color mapper: registers, hue and level pipelines,
// output color select. Depends on ncm_pkg, ncm_regs, ncm_hue_unit, ncm_level_unit.
//
// Usage:
//  - Input channel: in_valid / in_stall with value_odd and color_hint. A
//    transaction is taken at a clock edge with in_valid high, in_stall low.
//  - Output channel: out_valid / out_stall with red, green, blue, alpha.
//    Exactly one output transaction per input transaction, in order.
//  - There are 8 register stages from the input to out_valid, the first
//    loaded at the input edge. Throughput is one transaction per cycle
//    while out_stall is low; the long pole per stage is one multiplier
//    (hint * golden angle, the mod-45 reciprocal, the mid level scale).
//  - Each stage holds its own valid bit; a stalled receiver stops the last
//    stage and each full stage in an unbroken run before it, while empty
//    stages keep filling, so in_stall rises only once all 8 stages hold data.
//  - Reset (rst, synchronous) empties the pipeline and sets color_mode to
//    fixed and fixed_color to all ones.
//  - Configuration through an APB-style port; write only while idle.
//    Registers: color_mode at 0x0, fixed_color at 0x4.
`default_nettype none

module node_color_mapper_core import ncm_pkg::*; #(
  parameter int HINT_BITS = HintBitsDefault
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Configuration
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  // Input channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 value_odd,
  input  wire logic [HintWidth-1:0] color_hint,
  // Output channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [7:0]                red,
  output logic [7:0]                green,
  output logic [7:0]                blue,
  output logic [7:0]                alpha
);

  ncm_cfg_t    cfg;

  logic        hue_ready, hue_valid;
  logic [15:0] hue;
  logic        hue_odd;

  logic        lvl_ready, lvl_valid;
  sector_t     sector;
  logic [7:0]  mid;
  logic        mid_odd;

  logic        out_ready;
  logic [7:0]  red_c, green_c, blue_c, alpha_c;

  ncm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stages 1-4: hue = hint * golden angle mod full turn
  ncm_hue_unit #(
    .HINT_BITS (HINT_BITS)
  ) u_hue (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (in_valid),
    .up_ready   (hue_ready),
    .value_odd  (value_odd),
    .color_hint (color_hint),
    .down_valid (hue_valid),
    .down_ready (lvl_ready),
    .hue        (hue),
    .hue_odd    (hue_odd)
  );

  assign in_stall = !hue_ready;

  // Stages 5-7: sector and mid level
  ncm_level_unit u_level (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (hue_valid),
    .up_ready   (lvl_ready),
    .hue        (hue),
    .hue_odd    (hue_odd),
    .down_valid (lvl_valid),
    .down_ready (out_ready),
    .sector     (sector),
    .mid        (mid),
    .mid_odd    (mid_odd)
  );

  // Stage 8: output register
  assign out_ready = !out_valid || !out_stall;

  always_comb begin
    red_c   = 8'hFF;
    green_c = 8'hFF;
    blue_c  = 8'hFF;
    alpha_c = 8'hFF;
    unique case (cfg.color_mode)
      MODE_FIXED: begin
        red_c   = cfg.fixed_color[31:24];
        green_c = cfg.fixed_color[23:16];
        blue_c  = cfg.fixed_color[15:8];
        alpha_c = cfg.fixed_color[7:0];
      end
      MODE_PARITY: begin
        // odd: orange, even: blue
        red_c   = mid_odd ? 8'd255 : 8'd100;
        green_c = mid_odd ? 8'd140 : 8'd149;
        blue_c  = mid_odd ? 8'd0   : 8'd237;
      end
      MODE_HUE: begin
        case (sector)
          3'd0: begin
            red_c = LevelHigh; green_c = mid;       blue_c = LevelLow;
          end
          3'd1: begin
            red_c = mid;       green_c = LevelHigh; blue_c = LevelLow;
          end
          3'd2: begin
            red_c = LevelLow;  green_c = LevelHigh; blue_c = mid;
          end
          3'd3: begin
            red_c = LevelLow;  green_c = mid;       blue_c = LevelHigh;
          end
          3'd4: begin
            red_c = mid;       green_c = LevelLow;  blue_c = LevelHigh;
          end
          default: begin
            red_c = LevelHigh; green_c = LevelLow;  blue_c = mid;
          end
        endcase
      end
      default: ;  // MODE_WHITE leaves all channels at 0xFF
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= lvl_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      red   <= red_c;
      green <= green_c;
      blue  <= blue_c;
      alpha <= alpha_c;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ncm_regs.sv
// APB-style configuration registers of the node color mapper.
// Depends on ncm_pkg.
`default_nettype none

module ncm_regs import ncm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output ncm_cfg_t         cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.color_mode  <= MODE_FIXED;
      cfg.fixed_color <= 32'hFFFF_FFFF;
    end else if (wr_en) begin
      unique case (paddr)
        AddrColorMode:  cfg.color_mode  <= color_mode_t'(pwdata[1:0]);
        AddrFixedColor: cfg.fixed_color <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      AddrColorMode:  prdata = {30'd0, cfg.color_mode};
      AddrFixedColor: prdata = cfg.fixed_color;
      default:        prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/ncm_hue_unit.sv
// Hue pipeline: hint * golden angle, then mod 46080 by a reciprocal multiply.
// Four register stages. Depends on ncm_pkg.
`default_nettype none

module ncm_hue_unit import ncm_pkg::*; #(
  parameter int HINT_BITS = HintBitsDefault
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 up_valid,
  output logic                      up_ready,
  input  wire logic                 value_odd,
  input  wire logic [HintWidth-1:0] color_hint,
  output logic                      down_valid,
  input  wire logic                 down_ready,
  output logic [15:0]               hue,
  output logic                      hue_odd
);

  localparam int HW  = (HINT_BITS < HintWidth) ? HINT_BITS : HintWidth;
  localparam int PW  = HW + 15;   // hint * golden
  localparam int XW  = HW + 5;    // product / 1024
  localparam int QPW = HW + 27;   // x * reciprocal

  logic v1, v2, v3, v4;
  logic r1, r2, r3, r4;

  logic [HW-1:0]  hint;
  logic           odd1, odd2, odd3;
  logic [PW-1:0]  prod;
  logic [QPW-1:0] qprod;
  logic [HW-1:0]  quot;
  logic [XW-1:0]  xr;
  logic [9:0]     lo10;
  logic [XW-1:0]  rem;

  assign r4 = !v4 || down_ready;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign up_ready   = r1;
  assign down_valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r1) v1 <= up_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
    end
  end

  assign qprod = QPW'(prod[PW-1:10]) * QPW'(Recip45);
  assign rem   = xr - XW'(quot) * XW'(Mod45);

  always_ff @(posedge clk) begin
    if (r1) begin
      hint <= color_hint[HW-1:0];
      odd1 <= value_odd;
    end
    if (r2) begin
      prod <= PW'(hint) * PW'(Golden);
      odd2 <= odd1;
    end
    if (r3) begin
      quot <= qprod[QPW-1:RecipShift];
      xr   <= prod[PW-1:10];
      lo10 <= prod[9:0];
      odd3 <= odd2;
    end
    if (r4) begin
      hue     <= {rem[5:0], lo10};
      hue_odd <= odd3;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ncm_level_unit.sv
// Level pipeline: sector pick and mid channel level from the hue.
// Three register stages. Depends on ncm_pkg.
`default_nettype none

module ncm_level_unit import ncm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        up_valid,
  output logic             up_ready,
  input  wire logic [15:0] hue,
  input  wire logic        hue_odd,
  output logic             down_valid,
  input  wire logic        down_ready,
  output sector_t          sector,
  output logic [7:0]       mid,
  output logic             mid_odd
);

  logic v5, v6, v7;
  logic r5, r6, r7;

  sector_t     sec_c, sec5, sec6;
  logic [15:0] base_c;
  logic [12:0] off_c;
  logic [12:0] t5;
  logic [26:0] num6;
  logic [30:0] mprod;
  logic        odd5, odd6;

  assign r7 = !v7 || down_ready;
  assign r6 = !v6 || r7;
  assign r5 = !v5 || r6;
  assign up_ready   = r5;
  assign down_valid = v7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (r5) v5 <= up_valid;
      if (r6) v6 <= v5;
      if (r7) v7 <= v6;
    end
  end

  // Sector by compare against multiples of 60 degrees
  always_comb begin
    if (hue >= 16'(5 * Sector))      sec_c = 3'd5;
    else if (hue >= 16'(4 * Sector)) sec_c = 3'd4;
    else if (hue >= 16'(3 * Sector)) sec_c = 3'd3;
    else if (hue >= 16'(2 * Sector)) sec_c = 3'd2;
    else if (hue >= 16'(Sector))     sec_c = 3'd1;
    else                             sec_c = 3'd0;
    base_c = 16'(sec_c) * 16'(Sector);
  end

  assign off_c = 13'(hue - base_c);

  // (n / 4096) / 75 == n / 307200
  assign mprod = 31'(num6[26:12]) * 31'(MidRecip);

  always_ff @(posedge clk) begin
    if (r5) begin
      sec5 <= sec_c;
      t5   <= sec_c[0] ? 13'(Sector) - off_c : off_c;
      odd5 <= hue_odd;
    end
    if (r6) begin
      num6 <= 27'(MidBase) + 27'(t5) * 27'(MidSlope);
      sec6 <= sec5;
      odd6 <= odd5;
    end
    if (r7) begin
      mid     <= mprod[MidShift+7:MidShift];
      sector  <= sec6;
      mid_odd <= odd6;
    end
  end

endmodule

`default_nettype wire
